[design/range_packet_admission_gate_assert.svh]
// assertion macros for the range packet admission gate
// the macros expect clk and rst_n in the scope where they are used
`ifndef RANGE_PACKET_ADMISSION_GATE_ASSERT_SVH
`define RANGE_PACKET_ADMISSION_GATE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define RPAG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RPAG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RPAG_ASSERT_IMP(label, ante, cons, msg)
`define RPAG_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[design/rpag_pkg.sv]
package rpag_pkg;

  // result codes
  typedef enum logic [2:0] {
    VERD_ADMIT    = 3'd0,
    VERD_BAD_NODE = 3'd1,
    VERD_TIME     = 3'd2,
    VERD_DUP      = 3'd3,
    VERD_OOO      = 3'd4,
    VERD_TICK     = 3'd5
  } verdict_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_NODES_IN_USE = 2'd0,
    CFG_FUTURE_SKEW  = 2'd1,
    CFG_RECV_DELAY   = 2'd2,
    CFG_DEDUP_DEPTH  = 2'd3
  } cfg_idx_t;

  // item kinds
  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // reset values of the configuration registers
  localparam logic [3:0]  NODES_IN_USE_RST = 4'd8;
  localparam logic [39:0] FUTURE_SKEW_RST  = 40'd50000000;
  localparam logic [39:0] RECV_DELAY_RST   = 40'd100000000;
  localparam logic [4:0]  DEDUP_DEPTH_RST  = 5'd16;

  // one remembered packet of a directed link
  typedef struct packed {
    logic [31:0] seq;
    logic [63:0] stamp;
  } entry_t;

endpackage

[design/rpag_if.sv]
// input channel: range packets and ticks
interface rpag_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [2:0]  src_node;
  logic [2:0]  dst_node;
  logic [31:0] seq_number;
  logic [63:0] meas_time;
  logic [63:0] recv_time;

  modport source (output valid, action, src_node, dst_node, seq_number, meas_time,
                  recv_time, input ready);
  modport sink (input valid, action, src_node, dst_node, seq_number, meas_time,
                recv_time, output ready);
endinterface

// result channel: one beat per input item
interface rpag_out_if;
  logic              valid;
  logic              ready;
  rpag_pkg::verdict_t verdict;
  logic [63:0]       latest_time;
  logic              any_sync_fault;

  modport source (output valid, verdict, latest_time, any_sync_fault, input ready);
  modport sink (input valid, verdict, latest_time, any_sync_fault, output ready);
endinterface

[design/rpag_entry_ram.sv]
module rpag_entry_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  rpag_pkg::entry_t     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output rpag_pkg::entry_t     rd_data
);
  import rpag_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/rpag_link_table.sv]
module rpag_link_table #(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6,
  parameter int DATA_W  = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [DATA_W-1:0] rd_data
);
  import rpag_pkg::*;

  logic [DATA_W-1:0]  mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  logic [DATA_W-1:0]  rd_data_r;

  // per-link valid bits, cleared at reset so every FIFO starts empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // registered read, an unwritten link reads as empty
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_idx] ? mem[rd_idx] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/range_packet_admission_gate.sv]
// Range packet admission gate.
// in_chan carries range packets (action 0) and ticks (action 1); out_chan returns one
// beat per item with the verdict, the latest time and the any-sync-fault flag.
// Write the registers over cfg_* only while the block is idle; the block does not enforce this.
// Items are handled one at a time. A tick goes from S_CHK to S_RESP; a packet rejected
// for its nodes or its times goes through S_CHK, S_TIME and S_RESP; a packet that goes
// through the duplicate search also passes S_SRCH and then S_INS, or leaves S_SRCH
// early for S_RESP when a duplicate is found. F is the number of entries its directed
// link FIFO holds (at most FIFO_DEPTH). The search reads one FIFO entry per cycle from
// the single read port of the entry RAM, so F sets the packet rate.
// in_chan.ready is high only between items. A finished result sits in the output
// register; the next item is accepted while it waits, but that item's result is held
// back (and the input stays closed) until the receiver takes the earlier beat.
// Reset empties every link FIFO through per-link valid bits (no clearing pass),
// clears all edge fault bits, marks the latest time invalid and restores the
// register defaults. Entry RAM contents are undefined until written.
module range_packet_admission_gate #(
  parameter int NODE_CAP   = 8,
  parameter int FIFO_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  rpag_pkg::cfg_idx_t cfg_index,
  input  logic [39:0]       cfg_wr_data,
  rpag_in_if.sink           in_chan,
  rpag_out_if.source        out_chan
);
  import rpag_pkg::*;

  localparam int NODES_USED = (NODE_CAP < 8) ? NODE_CAP : 8;
  localparam int NLINKS     = NODES_USED * NODES_USED;
  localparam int LINK_W     = $clog2(NLINKS);
  localparam int SLOT_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
  localparam int META_W     = FILL_W + SLOT_W;
  localparam int RAM_DEPTH  = NLINKS * FIFO_DEPTH;
  localparam int ADDR_W     = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int CW         = (FILL_W > 5) ? FILL_W : 5;
  localparam logic [6:0] MAXN = 7'(NODE_CAP);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_TIME = 6'b000100,
    S_SRCH = 6'b001000,
    S_INS  = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  // configuration registers
  logic [3:0]  nodes_in_use_r;
  logic [39:0] skew_r;
  logic [39:0] delay_r;
  logic [4:0]  depth_r;

  // control state
  state_t              state_r, state_nxt;
  logic [63:0]         latest_r, latest_nxt;
  logic                latest_vld_r, latest_vld_nxt;
  logic [NLINKS-1:0]   fault_r, fault_nxt;
  verdict_t            verdict_r, verdict_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [FILL_W-1:0]   iss_cnt_r, iss_cnt_nxt;
  logic [FILL_W-1:0]   cmp_cnt_r, cmp_cnt_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  // item payload and per-item working values
  logic                action_r;
  logic [2:0]          src_r, dst_r;
  logic [31:0]         seq_r;
  logic [63:0]         meas_r, recv_r;
  logic [LINK_W-1:0]   link_r, edge_r;
  logic [ADDR_W-1:0]   base_r;
  logic                bad_node_r;
  logic                borrow_r;
  logic [63:0]         dmr_r, drm_r;
  verdict_t            out_verdict_r;
  logic [63:0]         out_latest_r;
  logic                out_fault_r;

  // combinational helpers
  logic [6:0]          limit;
  logic                bad_node_c;
  logic [2:0]          lo_node, hi_node;
  logic [LINK_W-1:0]   link_c, edge_c;
  logic [64:0]         diff_mr;
  logic [63:0]         diff_rm;
  logic                time_bad;
  logic [CW-1:0]       depth_ext, depth_eff;
  logic                out_free;
  logic                issue;
  logic                key_hit;
  logic [SLOT_W-1:0]   slot_inc, head_inc;

  // ram ports
  logic                ent_wr_en, ent_rd_en;
  logic [ADDR_W-1:0]   ent_addr;
  entry_t              ent_wr_data, ent_rd_data;
  logic                meta_wr_en, meta_rd_en;
  logic [META_W-1:0]   meta_wr_data, meta_rd_data;

  rpag_entry_ram #(
    .DEPTH  (RAM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_addr),
    .wr_data (ent_wr_data),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_addr),
    .rd_data (ent_rd_data)
  );

  rpag_link_table #(
    .ENTRIES (NLINKS),
    .IDX_W   (LINK_W),
    .DATA_W  (META_W)
  ) u_link_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (meta_wr_en),
    .wr_idx  (link_r),
    .wr_data (meta_wr_data),
    .rd_en   (meta_rd_en),
    .rd_idx  (link_c),
    .rd_data (meta_rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_in_use_r <= NODES_IN_USE_RST;
      skew_r         <= FUTURE_SKEW_RST;
      delay_r        <= RECV_DELAY_RST;
      depth_r        <= DEDUP_DEPTH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_NODES_IN_USE: nodes_in_use_r <= cfg_wr_data[3:0];
        CFG_FUTURE_SKEW:  skew_r         <= cfg_wr_data;
        CFG_RECV_DELAY:   delay_r        <= cfg_wr_data;
        CFG_DEDUP_DEPTH:  depth_r        <= cfg_wr_data[4:0];
        default: ;
      endcase
    end
  end

  // node check, link and edge numbering
  always_comb begin
    limit      = ({3'b000, nodes_in_use_r} > MAXN) ? MAXN : {3'b000, nodes_in_use_r};
    bad_node_c = (src_r == dst_r) || ({4'b0000, src_r} >= limit) ||
                 ({4'b0000, dst_r} >= limit);
    lo_node    = (src_r < dst_r) ? src_r : dst_r;
    hi_node    = (src_r < dst_r) ? dst_r : src_r;
    link_c     = LINK_W'(src_r) * LINK_W'(NODES_USED) + LINK_W'(dst_r);
    edge_c     = LINK_W'(lo_node) * LINK_W'(NODES_USED) + LINK_W'(hi_node);
    diff_mr    = {1'b0, meas_r} - {1'b0, recv_r};
    diff_rm    = recv_r - meas_r;
  end

  // time windows, on the differences registered in S_CHK
  assign time_bad = (recv_r == '0) ||
                    (!borrow_r && (dmr_r > {24'd0, skew_r})) ||
                    (borrow_r && (drm_r > {24'd0, delay_r}));

  // effective FIFO depth
  always_comb begin
    depth_ext = (depth_r == '0) ? CW'(1) : CW'(depth_r);
    depth_eff = (depth_ext > CW'(FIFO_DEPTH)) ? CW'(FIFO_DEPTH) : depth_ext;
  end

  assign slot_inc = (slot_r == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
  assign head_inc = (head_r == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : head_r + SLOT_W'(1);
  assign issue    = (state_r == S_SRCH) && (iss_cnt_r < fill_r);
  assign key_hit  = (ent_rd_data.seq == seq_r) && (ent_rd_data.stamp == meas_r);
  assign out_free = !out_valid_r || out_chan.ready;

  // ram control
  always_comb begin
    ent_rd_en         = issue;
    ent_wr_en         = (state_r == S_INS);
    ent_addr          = base_r + ADDR_W'(slot_r);
    ent_wr_data.seq   = seq_r;
    ent_wr_data.stamp = meas_r;
    meta_rd_en        = (state_r == S_CHK);
    meta_wr_en        = (state_r == S_INS);
    if (CW'(fill_r) < depth_eff) begin
      meta_wr_data = {fill_r + FILL_W'(1), head_r};
    end else begin
      meta_wr_data = {fill_r, head_inc};
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    latest_nxt     = latest_r;
    latest_vld_nxt = latest_vld_r;
    fault_nxt      = fault_r;
    verdict_nxt    = verdict_r;
    fill_nxt       = fill_r;
    head_nxt       = head_r;
    slot_nxt       = slot_r;
    iss_cnt_nxt    = iss_cnt_r;
    cmp_cnt_nxt    = cmp_cnt_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = S_CHK;
        end
      end
      // tick update, or start the link table read
      S_CHK: begin
        if (action_r == ACT_TICK) begin
          if (!latest_vld_r || (meas_r > latest_r)) begin
            latest_nxt = meas_r;
          end
          latest_vld_nxt = 1'b1;
          verdict_nxt    = VERD_TICK;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_TIME;
        end
      end
      // node and time verdicts, load the FIFO pointers
      S_TIME: begin
        fill_nxt    = meta_rd_data[META_W-1:SLOT_W];
        head_nxt    = meta_rd_data[SLOT_W-1:0];
        slot_nxt    = meta_rd_data[SLOT_W-1:0];
        iss_cnt_nxt = '0;
        cmp_cnt_nxt = '0;
        if (bad_node_r) begin
          verdict_nxt = VERD_BAD_NODE;
          state_nxt   = S_RESP;
        end else if (time_bad) begin
          fault_nxt[edge_r] = 1'b1;
          verdict_nxt       = VERD_TIME;
          state_nxt         = S_RESP;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      // one read issued and one entry compared per cycle
      S_SRCH: begin
        if (issue) begin
          slot_nxt    = slot_inc;
          iss_cnt_nxt = iss_cnt_r + FILL_W'(1);
        end
        pend_nxt = issue;
        if (pend_r) begin
          cmp_cnt_nxt = cmp_cnt_r + FILL_W'(1);
        end
        if (pend_r && key_hit) begin
          verdict_nxt = VERD_DUP;
          state_nxt   = S_RESP;
        end else if (cmp_cnt_nxt == fill_r) begin
          state_nxt = S_INS;
        end
      end
      // append to the FIFO, then the order check
      S_INS: begin
        if (latest_vld_r && (meas_r < latest_r)) begin
          verdict_nxt = VERD_OOO;
        end else begin
          fault_nxt[edge_r] = 1'b0;
          latest_nxt        = meas_r;
          latest_vld_nxt    = 1'b1;
          verdict_nxt       = VERD_ADMIT;
        end
        state_nxt = S_RESP;
      end
      // hand the result to the output register
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      latest_r     <= '0;
      latest_vld_r <= 1'b0;
      fault_r      <= '0;
      verdict_r    <= VERD_ADMIT;
      fill_r       <= '0;
      head_r       <= '0;
      slot_r       <= '0;
      iss_cnt_r    <= '0;
      cmp_cnt_r    <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      latest_r     <= latest_nxt;
      latest_vld_r <= latest_vld_nxt;
      fault_r      <= fault_nxt;
      verdict_r    <= verdict_nxt;
      fill_r       <= fill_nxt;
      head_r       <= head_nxt;
      slot_r       <= slot_nxt;
      iss_cnt_r    <= iss_cnt_nxt;
      cmp_cnt_r    <= cmp_cnt_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload capture and per-item working values
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_chan.valid) begin
      action_r <= in_chan.action;
      src_r    <= in_chan.src_node;
      dst_r    <= in_chan.dst_node;
      seq_r    <= in_chan.seq_number;
      meas_r   <= in_chan.meas_time;
      recv_r   <= in_chan.recv_time;
    end
    if (state_r == S_CHK) begin
      bad_node_r <= bad_node_c;
      link_r     <= link_c;
      edge_r     <= edge_c;
      base_r     <= ADDR_W'(link_c) * ADDR_W'(FIFO_DEPTH);
      borrow_r   <= diff_mr[64];
      dmr_r      <= diff_mr[63:0];
      drm_r      <= diff_rm;
    end
    if ((state_r == S_RESP) && out_free) begin
      out_verdict_r <= verdict_r;
      out_latest_r  <= latest_r;
      out_fault_r   <= |fault_r;
    end
  end

  // ports
  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.verdict        = out_verdict_r;
  assign out_chan.latest_time    = out_latest_r;
  assign out_chan.any_sync_fault = out_fault_r;

  // checks
`include "range_packet_admission_gate_assert.svh"
  `RPAG_ASSERT_IMP(a_search_bound, state_r == S_SRCH,
                   (iss_cnt_r <= fill_r) && (cmp_cnt_r <= fill_r),
                   "duplicate search ran past the FIFO fill")
  `RPAG_ASSERT_NXT(a_busy_after_accept, in_chan.valid && in_chan.ready,
                   !in_chan.ready, "input accepted a second item while busy")
  `RPAG_ASSERT_NXT(a_latest_monotonic, latest_vld_r,
                   latest_vld_r && (latest_r >= $past(latest_r)),
                   "latest time moved backward")

endmodule
